// ===== sv/dlps_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helpers of the direct Laplace potential sum unit.
package dlps_pkg;

  localparam int MaxSources = 1024;
  localparam int AddrW      = $clog2(MaxSources);
  localparam int CntW       = $clog2(MaxSources + 1);
  localparam int SrcW       = 128;

  localparam logic [31:0] ScaleReset = 32'd341782638;

  localparam logic signed [49:0] Max48 = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] Min48 = -50'sh0_8000_0000_0000;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_EVAL  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // Control from the sequencer to the shared square-root and divide unit.
  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } sd_ctrl_t;

  // Status back from that unit.
  typedef struct packed {
    logic        done;
    logic [47:0] result;
  } sd_stat_t;

  // Clamps a wide signed sum to 48 bits and reports whether it clamped.
  function automatic logic [48:0] sat48(input logic signed [49:0] s);
    logic [48:0] r;
    if (s > Max48) begin
      r = {1'b1, Max48[47:0]};
    end else if (s < Min48) begin
      r = {1'b1, Min48[47:0]};
    end else begin
      r = {1'b0, s[47:0]};
    end
    return r;
  endfunction

endpackage

// ===== sv/dlps_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and result items.
interface dlps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] source_density;
  logic [47:0] prior_potential;

  modport source (output valid, req_type, pos_x, pos_y, pos_z, source_density,
                  prior_potential, input ready);
  modport sink (input valid, req_type, pos_x, pos_y, pos_z, source_density,
                prior_potential, output ready);
endinterface

interface dlps_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] new_potential;
  logic        saturated;
  logic        store_full;

  modport source (output valid, new_potential, saturated, store_full, input ready);
  modport sink (input valid, new_potential, saturated, store_full, output ready);
endinterface

// ===== sv/dlps_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module dlps_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/dlps_mul.sv =====
`timescale 1ns / 1ps
// Shared 32 by 32 unsigned multiplier with a registered product.
module dlps_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p_r
);
  always_ff @(posedge clk) begin
    p_r <= 64'(a) * 64'(b);
  end
endmodule

// ===== sv/dlps_sqdiv.sv =====
`timescale 1ns / 1ps
// Iterative unit: floor square root of 66 bits or 48 by 33 bit division, one bit a cycle.
module dlps_sqdiv (
  input  logic               clk,
  input  logic               rst_n,
  input  dlps_pkg::sd_ctrl_t ctrl,
  input  logic [65:0]        opa,
  input  logic [32:0]        divisor,
  output dlps_pkg::sd_stat_t stat
);
  logic        busy_r, mode_r, done_r;
  logic [5:0]  cnt_r;
  logic [65:0] sh_r;
  logic [35:0] rem_r;
  logic [47:0] acc_r;
  logic [32:0] dv_r;
  logic [35:0] rem_s, sub_b;
  logic [36:0] diff;
  logic        ge;
  logic [5:0]  last;

  // One subtractor serves both the root trial and the divisor compare.
  always_comb begin
    if (mode_r) begin
      rem_s = {rem_r[33:0], sh_r[65:64]};
      sub_b = {1'b0, acc_r[32:0], 2'b01};
      last  = 6'd32;
    end else begin
      rem_s = {rem_r[34:0], sh_r[65]};
      sub_b = {3'b000, dv_r};
      last  = 6'd47;
    end
    diff = {1'b0, rem_s} - {1'b0, sub_b};
    ge   = ~diff[36];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == last) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      mode_r <= ctrl.sqrt_mode;
      cnt_r  <= '0;
      sh_r   <= opa;
      rem_r  <= '0;
      acc_r  <= '0;
      dv_r   <= divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      sh_r  <= mode_r ? {sh_r[63:0], 2'b00} : {sh_r[64:0], 1'b0};
      rem_r <= ge ? diff[35:0] : rem_s;
      acc_r <= {acc_r[46:0], ge};
    end
  end

  assign stat.done   = done_r;
  assign stat.result = acc_r;
endmodule

// ===== sv/direct_laplace_potential_sum_unit.sv =====
`timescale 1ns / 1ps
// Top level of the direct Laplace potential sum unit: source store and evaluation sequencer.
//
// The block keeps up to 1024 sources (position and density) in one RAM and
// answers evaluate items by walking every stored source in order. For each
// source the three squared differences go through one shared 32x32
// multiplier, then one shared bit-serial unit takes the floor square root and
// divides the density by the distance; the saturating 48-bit sum is scaled by
// kernel_scale in two multiplier passes. An evaluate item walks each stored
// source through S_RD, S_LAT, the squares, the root and the quotient, then does
// the scaling and the hand-off to the output register; a source at zero distance
// skips the root and the quotient. Clear items and unused request codes finish
// with no result, and an add item gives its result through S_WOUT and the output
// register after it is taken. The input is not ready while an item is being
// worked on; a finished result waits in an output register and a new item may
// be taken meanwhile. The source RAM needs no clearing after reset, since only
// entries below the source count are ever read. kernel_scale is to be written
// through cfg_we and cfg_wdata only while the block is idle; the block does not enforce it.
module direct_laplace_potential_sum_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  dlps_in_if.sink     in_ch,
  dlps_out_if.source  out_ch
);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_RD   = 13'b0000000000010,
    S_LAT  = 13'b0000000000100,
    S_SQX  = 13'b0000000001000,
    S_SQY  = 13'b0000000010000,
    S_SQZ  = 13'b0000000100000,
    S_SQE  = 13'b0000001000000,
    S_ROOT = 13'b0000010000000,
    S_QUOT = 13'b0000100000000,
    S_SC0  = 13'b0001000000000,
    S_SC1  = 13'b0010000000000,
    S_SC2  = 13'b0100000000000,
    S_WOUT = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] scale_r;
  logic [dlps_pkg::CntW-1:0]  count_r;
  logic [dlps_pkg::AddrW-1:0] idx_r;
  logic [31:0] tx_r, ty_r, tz_r;
  logic [47:0] prior_r;
  logic [31:0] mx_r, my_r, mz_r, dens_r;
  logic [65:0] r2_r;
  logic [47:0] acc_r;
  logic        sat_r;
  logic [31:0] lo_hi_r;
  logic [47:0] res_pot_r;
  logic        res_full_r;

  logic        out_valid_r;
  logic [47:0] out_pot_r;
  logic        out_sat_r, out_full_r;

  logic        accept, last_src, out_free;
  logic [dlps_pkg::SrcW-1:0] rdata;
  logic        ram_we;
  logic [32:0] dx, dy, dz;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [65:0] r2_fin;
  dlps_pkg::sd_ctrl_t sd_ctrl;
  dlps_pkg::sd_stat_t sd_stat;
  logic [65:0] sd_opa;
  logic [32:0] root;
  logic signed [48:0] term;
  logic [48:0] acc_sat, res_sat;
  logic [47:0] am, scaled_mag;
  logic signed [49:0] scaled;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign last_src    = ({1'b0, idx_r} + dlps_pkg::CntW'(1)) == count_r;

  assign ram_we = accept && in_ch.req_type == dlps_pkg::REQ_ADD &&
                  count_r < dlps_pkg::CntW'(dlps_pkg::MaxSources);

  dlps_ram #(.Width(dlps_pkg::SrcW), .Depth(dlps_pkg::MaxSources)) u_src_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[dlps_pkg::AddrW-1:0]),
    .wdata ({in_ch.pos_x, in_ch.pos_y, in_ch.pos_z, in_ch.source_density}),
    .raddr (idx_r),
    .rdata (rdata)
  );

  // Exact 33-bit differences between target and the source just read.
  assign dx = {tx_r[31], tx_r} - {rdata[127], rdata[127:96]};
  assign dy = {ty_r[31], ty_r} - {rdata[95], rdata[95:64]};
  assign dz = {tz_r[31], tz_r} - {rdata[63], rdata[63:32]};

  // The multiplier squares the distances, then scales the magnitude of the sum.
  assign am = acc_r[47] ? 48'(-acc_r) : acc_r;
  always_comb begin
    case (state_r)
      S_SQX:   begin mul_a = mx_r; mul_b = mx_r; end
      S_SQY:   begin mul_a = my_r; mul_b = my_r; end
      S_SQZ:   begin mul_a = mz_r; mul_b = mz_r; end
      S_SC0:   begin mul_a = am[31:0]; mul_b = scale_r; end
      S_SC1:   begin mul_a = {16'd0, am[47:32]}; mul_b = scale_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  dlps_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(prod));

  assign r2_fin = r2_r + {2'b00, prod};
  assign root   = (sd_stat.result[32:0] == '0) ? 33'd1 : sd_stat.result[32:0];

  // The root starts once the last square is in; the division starts when the root is done.
  always_comb begin
    sd_ctrl.start     = 1'b0;
    sd_ctrl.sqrt_mode = 1'b1;
    sd_opa            = r2_fin;
    if (state_r == S_SQE) begin
      sd_ctrl.start = (r2_fin != '0);
    end else if (state_r == S_ROOT) begin
      sd_ctrl.start     = sd_stat.done;
      sd_ctrl.sqrt_mode = 1'b0;
      sd_opa = {(dens_r[31] ? 32'(-dens_r) : dens_r), 16'd0, 18'd0};
    end
  end

  dlps_sqdiv u_sqdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (sd_ctrl),
    .opa     (sd_opa),
    .divisor (root),
    .stat    (sd_stat)
  );

  assign term    = dens_r[31] ? -$signed({1'b0, sd_stat.result}) :
                                $signed({1'b0, sd_stat.result});
  assign acc_sat = dlps_pkg::sat48(50'($signed(acc_r)) + 50'(term));

  // Product of the low half is shifted down by 32 and added to the high half.
  assign scaled_mag = prod[47:0] + {16'd0, lo_hi_r};
  assign scaled     = acc_r[47] ? -$signed({2'b00, scaled_mag}) :
                                  $signed({2'b00, scaled_mag});
  assign res_sat    = dlps_pkg::sat48(50'($signed(prior_r)) + scaled);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.req_type)
            dlps_pkg::REQ_ADD:  state_nxt = S_WOUT;
            dlps_pkg::REQ_EVAL: state_nxt = (count_r == '0) ? S_SC0 : S_RD;
            default:            state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD:   state_nxt = S_LAT;
      S_LAT:  state_nxt = S_SQX;
      S_SQX:  state_nxt = S_SQY;
      S_SQY:  state_nxt = S_SQZ;
      S_SQZ:  state_nxt = S_SQE;
      S_SQE: begin
        if (r2_fin != '0) begin
          state_nxt = S_ROOT;
        end else begin
          state_nxt = last_src ? S_SC0 : S_RD;
        end
      end
      S_ROOT: if (sd_stat.done) state_nxt = S_QUOT;
      S_QUOT: if (sd_stat.done) state_nxt = last_src ? S_SC0 : S_RD;
      S_SC0:  state_nxt = S_SC1;
      S_SC1:  state_nxt = S_SC2;
      S_SC2:  state_nxt = S_WOUT;
      S_WOUT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scale_r     <= dlps_pkg::ScaleReset;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        scale_r <= cfg_wdata;
      end
      if (accept && in_ch.req_type == dlps_pkg::REQ_CLEAR) begin
        count_r <= '0;
      end else if (ram_we) begin
        count_r <= count_r + dlps_pkg::CntW'(1);
      end
      if (state_r == S_WOUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tx_r       <= in_ch.pos_x;
      ty_r       <= in_ch.pos_y;
      tz_r       <= in_ch.pos_z;
      prior_r    <= in_ch.prior_potential;
      idx_r      <= '0;
      acc_r      <= '0;
      sat_r      <= 1'b0;
      res_pot_r  <= '0;
      res_full_r <= (in_ch.req_type == dlps_pkg::REQ_ADD) && !ram_we;
    end
    case (state_r)
      S_LAT: begin
        mx_r   <= dx[32] ? 32'(-dx) : dx[31:0];
        my_r   <= dy[32] ? 32'(-dy) : dy[31:0];
        mz_r   <= dz[32] ? 32'(-dz) : dz[31:0];
        dens_r <= rdata[31:0];
        r2_r   <= '0;
      end
      S_SQY, S_SQZ: r2_r <= r2_fin;
      S_SQE: if (r2_fin == '0) idx_r <= idx_r + dlps_pkg::AddrW'(1);
      S_QUOT: begin
        if (sd_stat.done) begin
          acc_r <= acc_sat[47:0];
          if (acc_sat[48]) sat_r <= 1'b1;
          idx_r <= idx_r + dlps_pkg::AddrW'(1);
        end
      end
      S_SC1: lo_hi_r <= prod[63:32];
      S_SC2: begin
        res_pot_r <= res_sat[47:0];
        sat_r     <= sat_r | res_sat[48];
      end
      default: ;
    endcase
    if (state_r == S_WOUT && out_free) begin
      out_pot_r  <= res_pot_r;
      out_sat_r  <= sat_r;
      out_full_r <= res_full_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.new_potential = out_pot_r;
  assign out_ch.saturated     = out_sat_r;
  assign out_ch.store_full    = out_full_r;

endmodule

// ===== sv/dlps_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions for the direct Laplace potential sum unit, with its bind.
module dlps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_req_type,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] out_new_potential,
  input logic        out_saturated,
  input logic        out_store_full
);
  // A waiting result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_potential))
    else $error("result changed while stalled");

  // An evaluate item keeps the block busy on the next cycle.
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == dlps_pkg::REQ_EVAL |=> !in_ready)
    else $error("input ready right after an evaluate item");

  // An add item taken with the output empty shows its result once it has passed S_WOUT and the output register.
  a_add_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == dlps_pkg::REQ_ADD && !out_valid
    |-> ##2 out_valid)
    else $error("add item gave no result");

  // A dropped source reports a zero potential and no saturation.
  a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_store_full |-> out_new_potential == '0 && !out_saturated)
    else $error("store-full result carries a potential");
endmodule

bind direct_laplace_potential_sum_unit dlps_checker u_dlps_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_req_type       (in_ch.req_type),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_new_potential (out_ch.new_potential),
  .out_saturated     (out_ch.saturated),
  .out_store_full    (out_ch.store_full)
);

// ===== tb/tb_direct_laplace_potential_sum_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the direct Laplace potential sum unit.
module tb_direct_laplace_potential_sum_unit;

  localparam int  CycleLimit = 3000000;
  localparam int  HoldCycles = 400;
  localparam longint PotMax  = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint PotMin  = -64'sh0000_8000_0000_0000;

  // One stimulus row. When check_fixed is set, the typed-in result is the
  // expectation; otherwise the predictor supplies it.
  typedef struct {
    dlps_pkg::req_t req;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] dens;
    logic [47:0] prior;
    bit          check_fixed;
    logic [47:0] fix_pot;
    bit          fix_sat;
    bit          fix_full;
  } row_t;

  typedef struct {
    logic [47:0] pot;
    bit          sat;
    bit          full;
  } potential_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  dlps_in_if  in_if();
  dlps_out_if out_if();

  direct_laplace_potential_sum_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  // The clock runs with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the block: scale register and source store.
  logic [31:0] shadow_scale = dlps_pkg::ScaleReset;
  logic [31:0] shadow_x [dlps_pkg::MaxSources];
  logic [31:0] shadow_y [dlps_pkg::MaxSources];
  logic [31:0] shadow_z [dlps_pkg::MaxSources];
  logic [31:0] shadow_dens [dlps_pkg::MaxSources];
  int unsigned shadow_count = 0;

  potential_t pending_results[$];
  int errors = 0;
  int unsigned cycles = 0;
  bit quiet = 1'b0;
  bit want_hold = 1'b0;
  bit hold_done = 1'b0;

  // Floor square root of a 66-bit value, two bits per step.
  function automatic logic [33:0] floor_sqrt66(input logic [65:0] v);
    logic [67:0] rem;
    logic [67:0] trial;
    logic [33:0] root;
    rem  = '0;
    root = '0;
    for (int k = 32; k >= 0; k--) begin
      rem   = (rem << 2) | 68'(v[2*k +: 2]);
      trial = (68'(root) << 2) | 68'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 34'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic longint sat_add48(input longint a, input longint b, inout bit sat);
    longint s;
    s = a + b;
    if (s > PotMax) begin
      sat = 1'b1;
      return PotMax;
    end
    if (s < PotMin) begin
      sat = 1'b1;
      return PotMin;
    end
    return s;
  endfunction

  // Sum of density over distance for every stored source, scaled and added
  // to the prior potential.
  function automatic potential_t target_potential(input row_t t);
    potential_t  res;
    longint      acc;
    longint      d;
    longint      term;
    longint      dv;
    longint      prior;
    logic [65:0] r2;
    logic [63:0] m;
    logic [63:0] r;
    logic [63:0] q;
    logic [63:0] am;
    logic [63:0] prod;
    bit          sat;
    acc = 0;
    sat = 1'b0;
    for (int j = 0; j < shadow_count; j++) begin
      r2 = '0;
      d = longint'(signed'(t.px)) - longint'(signed'(shadow_x[j]));
      m = (d < 0) ? -d : d;
      r2 += 66'(m) * 66'(m);
      d = longint'(signed'(t.py)) - longint'(signed'(shadow_y[j]));
      m = (d < 0) ? -d : d;
      r2 += 66'(m) * 66'(m);
      d = longint'(signed'(t.pz)) - longint'(signed'(shadow_z[j]));
      m = (d < 0) ? -d : d;
      r2 += 66'(m) * 66'(m);
      // A source at the target's own position contributes nothing.
      if (r2 == 0) continue;
      r = 64'(floor_sqrt66(r2));
      if (r == 0) r = 1;
      dv = longint'(signed'(shadow_dens[j]));
      m = (dv < 0) ? -dv : dv;
      q = (m << 16) / r;
      term = (dv < 0) ? -longint'(q) : longint'(q);
      acc = sat_add48(acc, term, sat);
    end
    am = (acc < 0) ? -acc : acc;
    prod = (am * 64'(shadow_scale[31:16]) + ((am * 64'(shadow_scale[15:0])) >> 16)) >> 16;
    prior = longint'(signed'(t.prior));
    res.pot  = 48'(sat_add48(prior, (acc < 0) ? -longint'(prod) : longint'(prod), sat));
    res.sat  = sat;
    res.full = 1'b0;
    return res;
  endfunction

  // Applies one accepted item to the shadow state; returns 1 when it yields a result.
  function automatic bit apply_item(input row_t t, output potential_t res);
    res = '{pot: '0, sat: 1'b0, full: 1'b0};
    case (t.req)
      dlps_pkg::REQ_CLEAR: begin
        shadow_count = 0;
        return 1'b0;
      end
      dlps_pkg::REQ_ADD: begin
        if (shadow_count < dlps_pkg::MaxSources) begin
          shadow_x[shadow_count]    = t.px;
          shadow_y[shadow_count]    = t.py;
          shadow_z[shadow_count]    = t.pz;
          shadow_dens[shadow_count] = t.dens;
          shadow_count++;
        end else begin
          res.full = 1'b1;
        end
        return 1'b1;
      end
      dlps_pkg::REQ_EVAL: begin
        res = target_potential(t);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Offers one item at a falling edge and waits for the block to take it.
  task automatic send_item(input row_t t);
    potential_t res;
    bit         has;
    while (!quiet && $urandom_range(99) < 19) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid           = 1'b1;
    in_if.req_type        = t.req;
    in_if.pos_x           = t.px;
    in_if.pos_y           = t.py;
    in_if.pos_z           = t.pz;
    in_if.source_density  = t.dens;
    in_if.prior_potential = t.prior;
    do @(posedge clk); while (!in_if.ready);
    has = apply_item(t, res);
    if (has) begin
      if (t.check_fixed) begin
        res = '{pot: t.fix_pot, sat: t.fix_sat, full: t.fix_full};
      end
      pending_results.push_back(res);
    end
    @(negedge clk);
  endtask

  // Waits until the block is idle, then writes the scale register.
  task automatic write_scale(input logic [31:0] v);
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    // Clear items and unused codes leave no result, so allow them to drain.
    repeat (10) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    shadow_scale = v;
  endtask

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(1)) return $urandom;
    return 32'($signed($urandom_range(2097152)) - 1048576);
  endfunction

  function automatic row_t rand_row();
    row_t t;
    int   pick;
    pick = $urandom_range(99);
    t.req = (pick < 5) ? dlps_pkg::REQ_CLEAR : (pick < 8) ? dlps_pkg::REQ_NONE :
            (pick < 55) ? dlps_pkg::REQ_ADD : dlps_pkg::REQ_EVAL;
    // Keep the store small so evaluations stay short.
    if (shadow_count >= 16 && t.req == dlps_pkg::REQ_ADD) t.req = dlps_pkg::REQ_CLEAR;
    t.px = rand_coord();
    t.py = rand_coord();
    t.pz = rand_coord();
    t.dens = $urandom;
    t.prior = ($urandom_range(9) < 3) ? 48'({$urandom, $urandom}) :
              48'($signed($urandom_range(65536000)) - 32768000);
    t.check_fixed = 1'b0;
    t.fix_pot = '0;
    t.fix_sat = 1'b0;
    t.fix_full = 1'b0;
    return t;
  endfunction

  // Directed rows: empty store, extremes, zero distance, tiny distance,
  // saturation, clear and the unused request code.
  row_t directed[$] = '{
    '{dlps_pkg::REQ_EVAL, 32'h0, 32'h0, 32'h0, 32'h0, 48'h7FFF_FFFF_FFFF,
      1'b1, 48'h7FFF_FFFF_FFFF, 1'b0, 1'b0},
    '{dlps_pkg::REQ_EVAL, 32'h0, 32'h0, 32'h0, 32'h0, 48'h8000_0000_0000,
      1'b1, 48'h8000_0000_0000, 1'b0, 1'b0},
    '{dlps_pkg::REQ_NONE, '1, '1, '1, '1, '1, 1'b0, '0, 1'b0, 1'b0},
    '{dlps_pkg::REQ_ADD, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 48'h0,
      1'b1, 48'h0, 1'b0, 1'b0},
    '{dlps_pkg::REQ_EVAL, 32'h0, 32'h0, 32'h0, 32'h0, 48'h5,
      1'b1, 48'h5, 1'b0, 1'b0},
    '{dlps_pkg::REQ_EVAL, 32'h1, 32'h0, 32'h0, 32'h0, 48'h0,
      1'b0, '0, 1'b0, 1'b0},
    '{dlps_pkg::REQ_ADD, 32'h0, 32'h0, 32'h1, 32'h7FFF_FFFF, 48'h0,
      1'b1, 48'h0, 1'b0, 1'b0},
    '{dlps_pkg::REQ_EVAL, 32'h1, 32'h0, 32'h0, 32'h0, 48'h0,
      1'b0, '0, 1'b0, 1'b0},
    '{dlps_pkg::REQ_EVAL, 32'h0, 32'h1, 32'h1, 32'h0, 48'h7FFF_FFFF_0000,
      1'b0, '0, 1'b0, 1'b0},
    '{dlps_pkg::REQ_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 48'h0,
      1'b1, 48'h0, 1'b0, 1'b0},
    '{dlps_pkg::REQ_EVAL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0,
      48'h8000_0000_0000, 1'b0, '0, 1'b0, 1'b0},
    '{dlps_pkg::REQ_EVAL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0,
      48'h7FFF_FFFF_FFFF, 1'b0, '0, 1'b0, 1'b0},
    '{dlps_pkg::REQ_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0, 48'h0,
      1'b0, '0, 1'b0, 1'b0},
    '{dlps_pkg::REQ_EVAL, 32'h0, 32'h0, 32'h0, 32'h0, 48'h1234_5678_9ABC,
      1'b1, 48'h1234_5678_9ABC, 1'b0, 1'b0},
    '{dlps_pkg::REQ_ADD, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 48'h0,
      1'b1, 48'h0, 1'b0, 1'b0},
    '{dlps_pkg::REQ_EVAL, 32'h0, 32'h0, 32'h1, 32'h0, 48'hFFFF_FFFF_FFFF,
      1'b0, '0, 1'b0, 1'b0},
    '{dlps_pkg::REQ_EVAL, 32'hFFFF_0000, 32'h0001_0000, 32'h0, 32'h0, 48'h8000_0000_0000,
      1'b0, '0, 1'b0, 1'b0},
    '{dlps_pkg::REQ_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0, 48'h0,
      1'b0, '0, 1'b0, 1'b0}
  };

  // Result receiver: random back-pressure, one long hold-off on request.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (want_hold && !hold_done) begin
        hold_done = 1'b1;
        out_if.ready = 1'b0;
        for (int c = 0; c < HoldCycles; c++) @(negedge clk);
      end
      out_if.ready = quiet || ($urandom_range(99) >= 19);
    end
  end

  // Every accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    potential_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result pot=%h sat=%b full=%b", $time,
                 out_if.new_potential, out_if.saturated, out_if.store_full);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_if.new_potential !== want.pot) begin
          $display("%0t: new_potential expected %h actual %h", $time, want.pot,
                   out_if.new_potential);
          errors++;
        end
        if (out_if.saturated !== want.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, want.sat, out_if.saturated);
          errors++;
        end
        if (out_if.store_full !== want.full) begin
          $display("%0t: store_full expected %b actual %b", $time, want.full,
                   out_if.store_full);
          errors++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.req_type = dlps_pkg::REQ_NONE;
    in_if.pos_x = '0;
    in_if.pos_y = '0;
    in_if.pos_z = '0;
    in_if.source_density = '0;
    in_if.prior_potential = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) send_item(directed[i]);

    // Four random phases, each with its own scale setting.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_scale(32'h0);
        1: write_scale(32'hFFFF_FFFF);
        2: write_scale(dlps_pkg::ScaleReset);
        default: write_scale($urandom);
      endcase
      if (ph == 1) want_hold = 1'b1;
      quiet = (ph == 2);
      for (int n = 0; n < 110; n++) send_item(rand_row());
      quiet = 1'b0;
    end
    in_if.valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
